// File: design/telnet_command_stream_parser_unit_defines.svh
// assertion macros for the telnet command stream parser
// used by the top level only; no other dependencies
`ifndef TELNET_COMMAND_STREAM_PARSER_UNIT_DEFINES_SVH
`define TELNET_COMMAND_STREAM_PARSER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// property holds at every rising clock edge out of reset
`define TCSP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition must never be seen out of reset
`define TCSP_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define TCSP_ASSERT(label, clk, rst_n, prop, msg)
`define TCSP_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

// File: design/tcsp_pkg.sv
// shared types and codes for the telnet command stream parser
// no dependencies
`timescale 1ns / 1ps

package tcsp_pkg;

  localparam int unsigned LEN_W = 15;

  localparam logic [7:0] CODE_IAC  = 8'd255;
  localparam logic [7:0] CODE_SB   = 8'd250;
  localparam logic [7:0] CODE_SE   = 8'd240;
  localparam logic [7:0] CODE_WILL = 8'd251;
  localparam logic [7:0] CODE_DONT = 8'd254;

  typedef enum logic [2:0] {
    PS_DATA   = 3'd0,
    PS_ESC    = 3'd1,
    PS_OPNEG  = 3'd2,
    PS_SUB    = 3'd3,
    PS_SUBESC = 3'd4,
    PS_ABORT  = 3'd5
  } parse_state_e;

  typedef enum logic [2:0] {
    K_DATA     = 3'd0,
    K_DATA_END = 3'd1,
    K_CMD      = 3'd2,
    K_OPNEG    = 3'd3,
    K_SUB      = 3'd4,
    K_SUB_END  = 3'd5,
    K_ABORT    = 3'd6
  } kind_e;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       chunk_end;
  } in_t;

  typedef struct packed {
    kind_e            kind;
    logic [7:0]       value;
    logic [7:0]       verb;
    logic [LEN_W-1:0] length;
    logic             last;
  } out_t;

  // one queue entry: the one or two result words caused by a byte
  typedef struct packed {
    logic two;
    out_t r0;
    out_t r1;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: design/telnet_command_stream_parser_unit.sv
// Telnet command stream parser: takes one stream byte per cycle and
// produces up to two result words per byte, one result word per cycle
// while the output is not stalled. A new byte is taken every cycle while
// the entry queue has room; the front end decodes IAC sequences, keeps
// the data and subnegotiation counts and folds the result words of one
// byte into one queue entry. The back end hands those words out one per
// cycle, unless stalled, through an output register, so a byte with two
// results holds the output for both words and the queue (QUEUE_DEPTH
// entries) soaks up such bursts. An accepted byte is written into the
// queue before its first word enters the output register. A data or
// subnegotiation run longer than BUFFER_LIMIT bytes gives one overflow
// abort word; after that every byte is taken and dropped until reset.
// Depends on tcsp_pkg, tcsp_front, tcsp_queue and tcsp_back.
`timescale 1ns / 1ps
`include "telnet_command_stream_parser_unit_defines.svh"

module telnet_command_stream_parser_unit #(
  parameter int unsigned BUFFER_LIMIT = 16384,
  parameter int unsigned QUEUE_DEPTH  = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  // input byte channel
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  tcsp_pkg::in_t  in_data_i,
  // result word channel
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output tcsp_pkg::out_t out_data_o
);
  import tcsp_pkg::*;

  // front to queue
  logic    push;
  entry_t  push_entry;
  // queue to back
  entry_t  head;
  logic    pop;
  q_stat_t q_stat;

  // byte decode, parse state and segment counters
  tcsp_front #(
    .BUFFER_LIMIT (BUFFER_LIMIT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  // decouples the decode rate from output back-pressure
  tcsp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_entry),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (q_stat)
  );

  // serialises each entry into single words on the output register
  tcsp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // the front must never push into a full queue
  `TCSP_NEVER(a_no_overflow, clk_i, rst_ni, push && q_stat.full, "queue overflow")
  // the back must never pop an empty queue
  `TCSP_NEVER(a_no_underflow, clk_i, rst_ni, pop && q_stat.empty, "queue underflow")
  // an abort word is always the only and final word of its byte
  `TCSP_ASSERT(a_abort_last, clk_i, rst_ni,
    (out_valid_o && out_data_o.kind == K_ABORT) |-> (out_data_o.last && out_data_o.length == '0),
    "abort word malformed")

endmodule

// File: design/tcsp_front.sv
// front end: takes stream bytes, runs the telnet parse state and counters
// and pushes the result words of each byte as one queue entry; uses tcsp_pkg
`timescale 1ns / 1ps

module tcsp_front #(
  parameter int unsigned BUFFER_LIMIT = 16384
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  tcsp_pkg::in_t    in_data_i,
  input  tcsp_pkg::q_stat_t q_stat_i,
  output logic             push_o,
  output tcsp_pkg::entry_t entry_o
);
  import tcsp_pkg::*;

  localparam int unsigned CNT_W = $clog2(BUFFER_LIMIT + 1);
  localparam logic [CNT_W-1:0] LIMIT = CNT_W'(BUFFER_LIMIT);
  localparam logic [CNT_W-1:0] ONE = CNT_W'(1);

  parse_state_e     state_q, state_d;
  logic [7:0]       last_cmd_q, last_cmd_d;
  logic [CNT_W-1:0] data_cnt_q, data_cnt_d;
  logic [CNT_W-1:0] sub_cnt_q, sub_cnt_d;

  out_t       slot [2];
  logic [1:0] n;
  logic [7:0] b;
  logic       accept;

  function automatic out_t mk_res(kind_e k, logic [7:0] v, logic [7:0] vb,
                                  logic [LEN_W-1:0] len);
    out_t r;
    r.kind   = k;
    r.value  = v;
    r.verb   = vb;
    r.length = len;
    r.last   = 1'b0;
    return r;
  endfunction

  assign b          = in_data_i.stream_byte;
  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d    = state_q;
    last_cmd_d = last_cmd_q;
    data_cnt_d = data_cnt_q;
    sub_cnt_d  = sub_cnt_q;
    n          = 2'd0;
    slot[0]    = mk_res(K_DATA, 8'd0, 8'd0, '0);
    slot[1]    = mk_res(K_DATA, 8'd0, 8'd0, '0);

    case (state_q)
      PS_DATA: begin
        if (b == CODE_IAC) begin
          state_d = PS_ESC;
        end else if (data_cnt_q >= LIMIT) begin
          state_d = PS_ABORT;
          slot[n[0]] = mk_res(K_ABORT, 8'd0, 8'd0, '0);
          n = n + 2'd1;
        end else begin
          data_cnt_d = data_cnt_q + ONE;
          slot[n[0]] = mk_res(K_DATA, b, 8'd0, '0);
          n = n + 2'd1;
        end
      end
      PS_ESC: begin
        last_cmd_d = b;
        if (b == CODE_IAC) begin
          // escaped 0xff is a data byte that also closes the segment
          state_d = PS_DATA;
          if (data_cnt_q >= LIMIT) begin
            state_d = PS_ABORT;
            slot[n[0]] = mk_res(K_ABORT, 8'd0, 8'd0, '0);
            n = n + 2'd1;
          end else begin
            data_cnt_d = data_cnt_q + ONE;
            slot[n[0]] = mk_res(K_DATA, b, 8'd0, '0);
            n = n + 2'd1;
          end
          if (state_d != PS_ABORT && data_cnt_d != '0) begin
            slot[n[0]] = mk_res(K_DATA_END, 8'd0, 8'd0, LEN_W'(data_cnt_d));
            n = n + 2'd1;
            data_cnt_d = '0;
          end
        end else if (b == CODE_SB) begin
          state_d   = PS_SUB;
          sub_cnt_d = '0;
        end else if (b >= CODE_WILL && b <= CODE_DONT) begin
          state_d = PS_OPNEG;
        end else begin
          state_d = PS_DATA;
          if (data_cnt_q != '0) begin
            slot[n[0]] = mk_res(K_DATA_END, 8'd0, 8'd0, LEN_W'(data_cnt_q));
            n = n + 2'd1;
            data_cnt_d = '0;
          end
          slot[n[0]] = mk_res(K_CMD, b, 8'd0, '0);
          n = n + 2'd1;
        end
      end
      PS_OPNEG: begin
        state_d = PS_DATA;
        if (data_cnt_q != '0) begin
          slot[n[0]] = mk_res(K_DATA_END, 8'd0, 8'd0, LEN_W'(data_cnt_q));
          n = n + 2'd1;
          data_cnt_d = '0;
        end
        slot[n[0]] = mk_res(K_OPNEG, b, last_cmd_q, '0);
        n = n + 2'd1;
      end
      PS_SUB, PS_SUBESC: begin
        if (state_q == PS_SUB && b == CODE_IAC) begin
          state_d = PS_SUBESC;
        end else if (state_q == PS_SUBESC && b == CODE_SE) begin
          // end of subnegotiation closes both segments
          state_d = PS_DATA;
          if (data_cnt_q != '0) begin
            slot[n[0]] = mk_res(K_DATA_END, 8'd0, 8'd0, LEN_W'(data_cnt_q));
            n = n + 2'd1;
            data_cnt_d = '0;
          end
          if (sub_cnt_q != '0) begin
            slot[n[0]] = mk_res(K_SUB_END, 8'd0, 8'd0, LEN_W'(sub_cnt_q));
            n = n + 2'd1;
            sub_cnt_d = '0;
          end
        end else begin
          state_d = PS_SUB;
          if (sub_cnt_q >= LIMIT) begin
            state_d = PS_ABORT;
            slot[n[0]] = mk_res(K_ABORT, 8'd0, 8'd0, '0);
            n = n + 2'd1;
          end else begin
            sub_cnt_d = sub_cnt_q + ONE;
            slot[n[0]] = mk_res(K_SUB, b, 8'd0, '0);
            n = n + 2'd1;
          end
        end
      end
      default: begin
        state_d = state_q;
      end
    endcase

    // chunk end flushes open data unless the parser has aborted
    if (in_data_i.chunk_end && state_d != PS_ABORT && state_q != PS_ABORT &&
        data_cnt_d != '0) begin
      slot[n[0]] = mk_res(K_DATA_END, 8'd0, 8'd0, LEN_W'(data_cnt_d));
      n = n + 2'd1;
      data_cnt_d = '0;
    end

    if (n == 2'd2) begin
      slot[1].last = 1'b1;
    end else begin
      slot[0].last = 1'b1;
    end
  end

  assign push_o     = accept && (n != 2'd0);
  assign entry_o.two = (n == 2'd2);
  assign entry_o.r0  = slot[0];
  assign entry_o.r1  = slot[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= PS_DATA;
      last_cmd_q <= 8'd0;
      data_cnt_q <= '0;
      sub_cnt_q  <= '0;
    end else if (accept) begin
      state_q    <= state_d;
      last_cmd_q <= last_cmd_d;
      data_cnt_q <= data_cnt_d;
      sub_cnt_q  <= sub_cnt_d;
    end
  end

endmodule

// File: design/tcsp_queue.sv
// short entry queue between front and back, head shown ahead
// uses tcsp_pkg
`timescale 1ns / 1ps

module tcsp_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tcsp_pkg::entry_t  push_data_i,
  input  logic              pop_i,
  output tcsp_pkg::entry_t  head_o,
  output tcsp_pkg::q_stat_t stat_o
);
  import tcsp_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  entry_t         mem_q [DEPTH];
  logic [PW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]  cnt_q, cnt_d;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == LAST_PTR) ? '0 : wr_q + PW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == LAST_PTR) ? '0 : rd_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  assign head_o       = mem_q[rd_q];
  assign stat_o.full  = (cnt_q == CW'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);

endmodule

// File: design/tcsp_back.sv
// back end: splits queue entries into single result words and drives
// the registered output channel; uses tcsp_pkg
`timescale 1ns / 1ps

module tcsp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tcsp_pkg::entry_t  head_i,
  input  tcsp_pkg::q_stat_t q_stat_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output tcsp_pkg::out_t    out_data_o
);
  import tcsp_pkg::*;

  logic sel_q, sel_d;
  logic out_valid_q, out_valid_d;
  out_t out_q;
  logic load;

  // move a word whenever the output register is free or being taken
  assign load  = !q_stat_i.empty && (!out_valid_q || !out_stall_i);
  assign pop_o = load && (sel_q || !head_i.two);

  always_comb begin
    sel_d       = sel_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (load) begin
      sel_d       = !sel_q && head_i.two;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= sel_q ? head_i.r1 : head_i.r0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: dv/telnet_command_stream_parser_unit_checker.sv
// result checker for the telnet command stream parser: decodes every accepted
// byte on its own and compares each result word with the oldest one expected
// depends on tcsp_pkg only
`timescale 1ns / 1ps

module telnet_command_stream_parser_unit_checker #(
  parameter int unsigned BUFFER_LIMIT = 16384
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_stall_i,
  input  tcsp_pkg::in_t  in_data_i,
  input  logic           out_valid_i,
  input  logic           out_stall_i,
  input  tcsp_pkg::out_t out_data_i,
  output int unsigned    pending_o,
  output int unsigned    error_count_o
);
  import tcsp_pkg::*;

  parse_state_e     parse_st = PS_DATA;
  logic [7:0]       last_cmd = '0;
  logic [LEN_W-1:0] data_len = '0;
  logic [LEN_W-1:0] sub_len  = '0;
  int unsigned      words_seen = 0;

  out_t byte_words[$];
  out_t expected_words[$];

  initial begin
    pending_o     = 0;
    error_count_o = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] result word %0d: %s", $time, words_seen, msg);
    error_count_o++;
  endtask

  task automatic add_word(input kind_e k, input logic [7:0] v, input logic [7:0] vb,
                          input logic [LEN_W-1:0] n);
    out_t w;
    w.kind   = k;
    w.value  = v;
    w.verb   = vb;
    w.length = n;
    w.last   = 1'b0;
    if (byte_words.size() < 2) byte_words.push_back(w);
  endtask

  // one more byte in a segment, or the abort once the segment is full
  task automatic grow(inout logic [LEN_W-1:0] count, input kind_e k, input logic [7:0] b);
    if (count >= BUFFER_LIMIT) begin
      parse_st = PS_ABORT;
      add_word(K_ABORT, '0, '0, '0);
    end else begin
      count++;
      add_word(k, b, '0, '0);
    end
  endtask

  task automatic close_data();
    if (parse_st != PS_ABORT && data_len != 0) begin
      add_word(K_DATA_END, '0, '0, data_len);
      data_len = '0;
    end
  endtask

  task automatic close_sub();
    if (parse_st != PS_ABORT && sub_len != 0) begin
      add_word(K_SUB_END, '0, '0, sub_len);
      sub_len = '0;
    end
  endtask

  task automatic decode_byte(input in_t w);
    logic [7:0] b;
    b = w.stream_byte;
    byte_words.delete();
    case (parse_st)
      PS_DATA: begin
        if (b == CODE_IAC) parse_st = PS_ESC;
        else grow(data_len, K_DATA, b);
      end
      PS_ESC: begin
        last_cmd = b;
        if (b == CODE_IAC) begin
          parse_st = PS_DATA;
          grow(data_len, K_DATA, b);
          close_data();
        end else if (b == CODE_SB) begin
          parse_st = PS_SUB;
          sub_len  = '0;
        end else if (b >= CODE_WILL && b <= CODE_DONT) begin
          parse_st = PS_OPNEG;
        end else begin
          parse_st = PS_DATA;
          close_data();
          add_word(K_CMD, b, '0, '0);
        end
      end
      PS_OPNEG: begin
        parse_st = PS_DATA;
        close_data();
        add_word(K_OPNEG, b, last_cmd, '0);
      end
      PS_SUB: begin
        if (b == CODE_IAC) parse_st = PS_SUBESC;
        else grow(sub_len, K_SUB, b);
      end
      PS_SUBESC: begin
        if (b == CODE_SE) begin
          parse_st = PS_DATA;
          close_data();
          close_sub();
        end else begin
          parse_st = PS_SUB;
          grow(sub_len, K_SUB, b);
        end
      end
      default: return;
    endcase
    if (w.chunk_end) close_data();
    if (byte_words.size() != 0) byte_words[byte_words.size() - 1].last = 1'b1;
    foreach (byte_words[i]) expected_words.push_back(byte_words[i]);
  endtask

  // results first: no word can leave in the cycle its byte is taken
  always @(posedge clk_i) begin
    out_t exp_w;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected, kind %0d value %0h length %0d",
                                    out_data_i.kind, out_data_i.value, out_data_i.length));
        end else begin
          exp_w = expected_words.pop_front();
          if (out_data_i.kind !== exp_w.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", out_data_i.kind, exp_w.kind));
          if (out_data_i.value !== exp_w.value)
            report_mismatch($sformatf("value %0h, expected %0h", out_data_i.value, exp_w.value));
          if (out_data_i.verb !== exp_w.verb)
            report_mismatch($sformatf("verb %0h, expected %0h", out_data_i.verb, exp_w.verb));
          if (out_data_i.length !== exp_w.length)
            report_mismatch($sformatf("length %0d, expected %0d",
                                      out_data_i.length, exp_w.length));
          if (out_data_i.last !== exp_w.last)
            report_mismatch($sformatf("last %0b, expected %0b", out_data_i.last, exp_w.last));
        end
        words_seen++;
      end
      if (in_valid_i && !in_stall_i) decode_byte(in_data_i);
      pending_o = expected_words.size();
    end
  end

endmodule

// File: dv/telnet_command_stream_parser_unit_tb.sv
// testbench top for the telnet command stream parser: drives directed and
// random telnet byte streams with random gaps and stalls, then gives the verdict
// depends on tcsp_pkg, the parser and telnet_command_stream_parser_unit_checker
`timescale 1ns / 1ps

module telnet_command_stream_parser_unit_tb;
  import tcsp_pkg::*;

  localparam int unsigned BUFFER_LIMIT = 16384;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // byte channel into the parser
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_word  = '0;

  // result word channel out of the parser
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_word;

  int unsigned pending;
  int unsigned error_count;

  // longest gap the sender leaves before a byte, longest stall per word
  int unsigned gap_max    = 11;
  int unsigned stall_max  = 11;
  int unsigned bytes_sent = 0;

  telnet_command_stream_parser_unit #(
    .BUFFER_LIMIT(BUFFER_LIMIT)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_word)
  );

  telnet_command_stream_parser_unit_checker #(
    .BUFFER_LIMIT(BUFFER_LIMIT)
  ) checker_inst (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_word),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_word),
    .pending_o    (pending),
    .error_count_o(error_count)
  );

  // 20 ns clock
  initial begin
    forever #10 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("telnet_command_stream_parser_unit_tb NOT OK");
    $finish;
  end

  // chunk boundaries on roughly one byte in six
  function automatic logic chunk_flag();
    return ($urandom_range(0, 5) == 0);
  endfunction

  // called at a falling edge; returns at the falling edge after the byte is taken.
  // valid is only ever assigned once per time step, so a back-to-back byte
  // keeps valid high without a glitch
  task automatic send_byte(input logic [7:0] b, input logic ce);
    int unsigned gap;
    in_t         w;
    gap = $urandom_range(0, gap_max);
    w.stream_byte = b;
    w.chunk_end   = ce;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  // receiver: a fresh stall length for every word, changed at the falling edge
  initial begin
    int unsigned hold;
    forever begin
      hold = $urandom_range(0, stall_max);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    int unsigned random_goal;
    int unsigned n;
    logic [7:0]  b;
    logic [7:0]  c;

    // reset held low at the start, released on a falling edge
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // ---- directed part ----
    // plain data, then a chunk end closing a three-byte segment
    send_byte(8'h00, 1'b0);
    send_byte(8'h7f, 1'b0);
    send_byte(8'hfe, 1'b1);
    // doubled IAC gives a literal 255 and closes the segment at once
    send_byte(CODE_IAC, 1'b0);
    send_byte(CODE_IAC, 1'b1);
    // chunk end while escaped, nothing open: no word at all
    send_byte(CODE_IAC, 1'b1);
    send_byte(8'hf1, 1'b0);
    // SE outside a subnegotiation is just a command, after closing open data
    send_byte(8'h41, 1'b0);
    send_byte(CODE_IAC, 1'b0);
    send_byte(CODE_SE, 1'b0);
    // negotiations with the lowest and highest verbs and option codes
    send_byte(CODE_IAC, 1'b0);
    send_byte(CODE_WILL, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(CODE_IAC, 1'b0);
    send_byte(CODE_DONT, 1'b0);
    send_byte(CODE_IAC, 1'b1);
    // subnegotiation opened while data is still open; escaped IAC and an
    // IAC followed by a non-SE byte both count as subneg bytes; the closing
    // SE ends data and subneg in one byte
    send_byte(8'h42, 1'b0);
    send_byte(CODE_IAC, 1'b0);
    send_byte(CODE_SB, 1'b0);
    send_byte(8'h18, 1'b0);
    send_byte(CODE_IAC, 1'b0);
    send_byte(CODE_IAC, 1'b0);
    send_byte(CODE_IAC, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(CODE_IAC, 1'b0);
    send_byte(CODE_SE, 1'b0);
    // empty subnegotiation: no end word
    send_byte(CODE_IAC, 1'b0);
    send_byte(CODE_SB, 1'b0);
    send_byte(CODE_IAC, 1'b0);
    send_byte(CODE_SE, 1'b1);

    // ---- random part ----
    // mostly well-formed sequences with random content, some raw noise
    random_goal = bytes_sent + 800;
    while (bytes_sent < random_goal) begin
      // now and then switch between heavy idling and none on either side
      if ($urandom_range(0, 11) == 0) begin
        gap_max   = $urandom_range(0, 1) ? 11 : 0;
        stall_max = $urandom_range(0, 1) ? 11 : 0;
      end
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          // data run, IAC doubled as the protocol wants
          n = $urandom_range(1, 8);
          repeat (n) begin
            b = $urandom_range(0, 255);
            if (b == CODE_IAC) send_byte(CODE_IAC, 1'b0);
            send_byte(b, chunk_flag());
          end
        end
        3: begin
          // plain command, any code that is neither SB nor a verb (IAC gives an escaped data byte)
          do c = $urandom_range(0, 255);
          while (c == CODE_SB || (c >= CODE_WILL && c <= CODE_DONT));
          send_byte(CODE_IAC, chunk_flag());
          send_byte(c, chunk_flag());
        end
        4, 5: begin
          send_byte(CODE_IAC, chunk_flag());
          b = $urandom_range(CODE_WILL, CODE_DONT);
          send_byte(b, chunk_flag());
          b = $urandom_range(0, 255);
          send_byte(b, chunk_flag());
        end
        6, 7: begin
          // subnegotiation, sometimes empty, with both kinds of escaped byte
          send_byte(CODE_IAC, chunk_flag());
          send_byte(CODE_SB, chunk_flag());
          n = $urandom_range(0, 6);
          repeat (n) begin
            b = $urandom_range(0, 255);
            if (b == CODE_IAC) begin
              send_byte(CODE_IAC, chunk_flag());
              if ($urandom_range(0, 1)) begin
                b = CODE_IAC;
              end else begin
                do b = $urandom_range(0, 255);
                while (b == CODE_SE);
              end
            end
            send_byte(b, chunk_flag());
          end
          send_byte(CODE_IAC, chunk_flag());
          send_byte(CODE_SE, chunk_flag());
        end
        default: begin
          // raw noise: broken and truncated sequences
          n = $urandom_range(1, 6);
          repeat (n) begin
            b = $urandom_range(0, 255);
            send_byte(b, chunk_flag());
          end
        end
      endcase
    end
    in_valid <= 1'b0;

    // drain, then leave time for any stray word to show up
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("telnet_command_stream_parser_unit_tb OK");
    end else begin
      $display("telnet_command_stream_parser_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
